// ----- src/dtrk_pkg.sv -----
// shared types and constants for the dependency depth tracker
`default_nettype none

package dtrk_pkg;

    localparam int NUM_REGS    = 32;
    localparam int REG_BITS    = 5;
    localparam int OP_BITS     = 5;
    localparam int LAT_BITS    = 8;
    localparam int NUM_LAT_WORDS = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_BITS    = 64;
    localparam int IDX_BITS    = 12;
    localparam int PROD_BITS   = 13;
    localparam int CNT_BITS    = 13;
    localparam int TIME_BITS   = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic [CNT_BITS-1:0]  MAX_INSTS  = CNT_BITS'(4096);
    localparam logic [IDX_BITS-1:0]  LAST_INDEX = {IDX_BITS{1'b1}};
    localparam logic [PROD_BITS-1:0] NO_WRITER  = {PROD_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};

    // one classified instruction on its way to the back end
    typedef struct packed {
        logic [LAT_BITS-1:0] latency;
        logic [REG_BITS-1:0] dest_reg;
        logic [REG_BITS-1:0] source_a;
        logic [REG_BITS-1:0] source_b;
        logic                new_program;
    } item_t;

    // writer table entry
    typedef struct packed {
        logic [IDX_BITS-1:0]  index;
        logic [TIME_BITS-1:0] finish;
    } entry_t;

endpackage

`default_nettype wire

// ----- src/dtrk_front.sv -----
// front end: latency table registers and classification of incoming instructions
`default_nettype none

module dtrk_front
    import dtrk_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    input  wire logic [OP_BITS-1:0]      opcode,
    input  wire logic [REG_BITS-1:0]     dest_reg,
    input  wire logic [REG_BITS-1:0]     source_a,
    input  wire logic [REG_BITS-1:0]     source_b,
    input  wire logic                    new_program,
    output item_t                        item
);

    logic [CFG_BITS-1:0] lat_word_reg [NUM_LAT_WORDS];
    logic [CFG_BITS-1:0] sel_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LAT_WORDS; i++)
            begin
                lat_word_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            lat_word_reg[cfg_index] <= cfg_data;
        end
    end

    // word by the upper opcode bits, byte by the lower three
    assign sel_word = lat_word_reg[opcode[4:3]];

    always_comb
    begin
        item.latency     = sel_word[{opcode[2:0], 3'b000} +: LAT_BITS];
        item.dest_reg    = dest_reg;
        item.source_a    = source_a;
        item.source_b    = source_b;
        item.new_program = new_program;
    end

endmodule

`default_nettype wire

// ----- src/dtrk_queue.sv -----
// short queue between the front and back ends
`default_nettype none

module dtrk_queue
    import dtrk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       not_full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);

    item_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic [QCNT_BITS-1:0]  count_next;

    assign not_full  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/dtrk_back.sv -----
// back end: writer table, depth arithmetic and result register
`default_nettype none

module dtrk_back
    import dtrk_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  item_t                      q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [IDX_BITS-1:0]        inst_index,
    output logic signed [PROD_BITS-1:0] producer_a,
    output logic signed [PROD_BITS-1:0] producer_b,
    output logic [TIME_BITS-1:0]       start_depth,
    output logic [TIME_BITS-1:0]       finish_time,
    output logic [TIME_BITS-1:0]       program_depth,
    output logic                       index_overflow
);

    // writer table memory, read into registers ahead of execution
    entry_t                mem [NUM_REGS];
    entry_t                rd_a_reg;
    entry_t                rd_b_reg;
    logic [NUM_REGS-1:0]   vld_reg;

    // execute stage
    logic                  e_valid_reg;
    item_t                 e_item_reg;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    entry_t                fwd_reg;

    logic [CNT_BITS-1:0]   cnt_reg;
    logic [TIME_BITS-1:0]  maxf_reg;

    logic                  out_valid_reg;
    logic [IDX_BITS-1:0]   out_idx_reg;
    logic [PROD_BITS-1:0]  out_pa_reg;
    logic [PROD_BITS-1:0]  out_pb_reg;
    logic [TIME_BITS-1:0]  out_start_reg;
    logic [TIME_BITS-1:0]  out_fin_reg;
    logic [TIME_BITS-1:0]  out_max_reg;
    logic                  out_ovf_reg;

    logic                  e_fire;
    logic [CNT_BITS-1:0]   cnt_cur;
    logic [TIME_BITS-1:0]  maxf_cur;
    logic                  ovf;
    logic [IDX_BITS-1:0]   idx;
    logic                  hit_a;
    logic                  hit_b;
    entry_t                ent_a;
    entry_t                ent_b;
    logic [TIME_BITS-1:0]  fin_a;
    logic [TIME_BITS-1:0]  fin_b;
    logic [TIME_BITS-1:0]  start;
    logic [TIME_BITS:0]    sum;
    logic [TIME_BITS-1:0]  fin;
    logic [TIME_BITS-1:0]  maxf_new;
    logic [NUM_REGS-1:0]   dest_bit;
    logic [PROD_BITS-1:0]  pa;
    logic [PROD_BITS-1:0]  pb;

    assign e_fire = e_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop  = q_valid && (!e_valid_reg || e_fire);

    always_comb
    begin
        cnt_cur  = e_item_reg.new_program ? '0 : cnt_reg;
        maxf_cur = e_item_reg.new_program ? '0 : maxf_reg;
        ovf      = (cnt_cur == MAX_INSTS);
        idx      = ovf ? LAST_INDEX : cnt_cur[IDX_BITS-1:0];

        // a new program sees an empty table
        hit_a = !e_item_reg.new_program && vld_reg[e_item_reg.source_a];
        hit_b = !e_item_reg.new_program && vld_reg[e_item_reg.source_b];
        ent_a = fwd_a_reg ? fwd_reg : rd_a_reg;
        ent_b = fwd_b_reg ? fwd_reg : rd_b_reg;
        fin_a = hit_a ? ent_a.finish : '0;
        fin_b = hit_b ? ent_b.finish : '0;
        pa    = hit_a ? {1'b0, ent_a.index} : NO_WRITER;
        pb    = hit_b ? {1'b0, ent_b.index} : NO_WRITER;

        start    = (fin_a > fin_b) ? fin_a : fin_b;
        sum      = {1'b0, start} + {{(TIME_BITS + 1 - LAT_BITS){1'b0}}, e_item_reg.latency};
        fin      = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
        maxf_new = (fin > maxf_cur) ? fin : maxf_cur;
        dest_bit = NUM_REGS'(1) << e_item_reg.dest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            maxf_reg      <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (e_fire)
            begin
                cnt_reg  <= ovf ? cnt_cur : cnt_cur + 1'b1;
                maxf_reg <= maxf_new;
                vld_reg  <= e_item_reg.new_program ? dest_bit : (vld_reg | dest_bit);
            end
        end
    end

    // table write on execute, reads issued as the item leaves the queue
    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            mem[e_item_reg.dest_reg] <= '{index: idx, finish: fin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_a_reg   <= mem[q_item.source_a];
            rd_b_reg   <= mem[q_item.source_b];
            e_item_reg <= q_item;
            // the read misses a write landing in the same cycle, so bypass it
            fwd_a_reg  <= e_fire && (e_item_reg.dest_reg == q_item.source_a);
            fwd_b_reg  <= e_fire && (e_item_reg.dest_reg == q_item.source_b);
            fwd_reg    <= '{index: idx, finish: fin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            out_idx_reg   <= idx;
            out_pa_reg    <= pa;
            out_pb_reg    <= pb;
            out_start_reg <= start;
            out_fin_reg   <= fin;
            out_max_reg   <= maxf_new;
            out_ovf_reg   <= ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign inst_index     = out_idx_reg;
    assign producer_a     = out_pa_reg;
    assign producer_b     = out_pb_reg;
    assign start_depth    = out_start_reg;
    assign finish_time    = out_fin_reg;
    assign program_depth  = out_max_reg;
    assign index_overflow = out_ovf_reg;

endmodule

`default_nettype wire

// ----- src/dataflow_dependency_depth_tracker.sv -----
// top level: front end, item queue and back end of the dependency depth tracker
// path: an instruction transfer goes through a queue slot, the table read into execute
// and the result register before its result is valid
// throughput: one instruction per cycle while out_ready keeps the result register moving,
// set by the execute stage max-add-write, with a bypass for the entry written just ahead
// reset: clears latency words, queue, writer valid bits, counter and program depth;
// the writer table memory itself is not cleared, its valid bits cover it
`default_nettype none

module dataflow_dependency_depth_tracker
    import dtrk_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_BITS-1:0]      opcode,
    input  wire logic [REG_BITS-1:0]     dest_reg,
    input  wire logic [REG_BITS-1:0]     source_a,
    input  wire logic [REG_BITS-1:0]     source_b,
    input  wire logic                    new_program,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [IDX_BITS-1:0]          inst_index,
    output logic signed [PROD_BITS-1:0]  producer_a,
    output logic signed [PROD_BITS-1:0]  producer_b,
    output logic [TIME_BITS-1:0]         start_depth,
    output logic [TIME_BITS-1:0]         finish_time,
    output logic [TIME_BITS-1:0]         program_depth,
    output logic                         index_overflow
);

    item_t front_item;
    item_t q_head;
    logic  q_not_full;
    logic  q_not_empty;
    logic  q_pop;

    dtrk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .dest_reg    (dest_reg),
        .source_a    (source_a),
        .source_b    (source_b),
        .new_program (new_program),
        .item        (front_item)
    );

    assign in_ready = q_not_full;

    dtrk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dtrk_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_not_empty),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .inst_index     (inst_index),
        .producer_a     (producer_a),
        .producer_b     (producer_b),
        .start_depth    (start_depth),
        .finish_time    (finish_time),
        .program_depth  (program_depth),
        .index_overflow (index_overflow)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the dataflow dependency depth tracker
module testbench;
    import dtrk_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 40;
    localparam int CHAIN_LEN = 40;
    localparam int PHASE_ITEMS = 120;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        LAT_WORD_0,
        LAT_WORD_1,
        LAT_WORD_2,
        LAT_WORD_3
    } lat_reg_t;

    typedef struct {
        logic [IDX_BITS-1:0]         index;
        logic signed [PROD_BITS-1:0] prod_a;
        logic signed [PROD_BITS-1:0] prod_b;
        logic [TIME_BITS-1:0]        start;
        logic [TIME_BITS-1:0]        finish;
        logic [TIME_BITS-1:0]        depth;
        logic                        overflow;
    } depth_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_BITS-1:0]           cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [OP_BITS-1:0]            opcode;
    logic [REG_BITS-1:0]           dest_reg;
    logic [REG_BITS-1:0]           source_a;
    logic [REG_BITS-1:0]           source_b;
    logic                          new_program;
    logic                          out_valid;
    logic                          out_ready;
    logic [IDX_BITS-1:0]           inst_index;
    logic signed [PROD_BITS-1:0]   producer_a;
    logic signed [PROD_BITS-1:0]   producer_b;
    logic [TIME_BITS-1:0]          start_depth;
    logic [TIME_BITS-1:0]          finish_time;
    logic [TIME_BITS-1:0]          program_depth;
    logic                          index_overflow;

    // predictor state
    logic [CFG_BITS-1:0]  lat_shadow [NUM_LAT_WORDS];
    logic [NUM_REGS-1:0]  writer_known;
    logic [IDX_BITS-1:0]  writer_idx [NUM_REGS];
    logic [TIME_BITS-1:0] writer_fin [NUM_REGS];
    logic [CNT_BITS-1:0]  inst_count;
    logic [TIME_BITS-1:0] deepest_fin;

    depth_result_t pending_results[$];

    int  errors = 0;
    int  cycles = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_overflow = 0;
    int  n_saturated = 0;
    int  n_programs = 0;
    int  stall_left = 0;
    int  ready_roll;
    bit  quiet = 1'b0;

    dataflow_dependency_depth_tracker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .dest_reg       (dest_reg),
        .source_a       (source_a),
        .source_b       (source_b),
        .new_program    (new_program),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .inst_index     (inst_index),
        .producer_a     (producer_a),
        .producer_b     (producer_b),
        .start_depth    (start_depth),
        .finish_time    (finish_time),
        .program_depth  (program_depth),
        .index_overflow (index_overflow)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [REG_BITS-1:0] pick_reg();
        // mostly a few hot registers so that dependencies form
        if ($urandom_range(0, 3) == 0)
            return REG_BITS'($urandom_range(0, NUM_REGS - 1));
        return REG_BITS'($urandom_range(0, 5));
    endfunction

    function automatic void clear_program_state();
        writer_known = '0;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            writer_idx[r] = '0;
            writer_fin[r] = '0;
        end
        inst_count = '0;
        deepest_fin = '0;
    endfunction

    function automatic depth_result_t track_instruction(
        logic [OP_BITS-1:0] op, logic [REG_BITS-1:0] d, logic [REG_BITS-1:0] a,
        logic [REG_BITS-1:0] b, logic np);
        depth_result_t r;
        logic [TIME_BITS-1:0] fin_a;
        logic [TIME_BITS-1:0] fin_b;
        logic [LAT_BITS-1:0]  lat;
        logic [TIME_BITS:0]   sum;
        if (np)
            clear_program_state();
        r.overflow = (inst_count >= MAX_INSTS);
        r.index = r.overflow ? LAST_INDEX : inst_count[IDX_BITS-1:0];
        if (!r.overflow)
            inst_count++;
        // sources are looked up before the destination entry changes
        r.prod_a = writer_known[a] ? {1'b0, writer_idx[a]} : NO_WRITER;
        r.prod_b = writer_known[b] ? {1'b0, writer_idx[b]} : NO_WRITER;
        fin_a = writer_known[a] ? writer_fin[a] : '0;
        fin_b = writer_known[b] ? writer_fin[b] : '0;
        r.start = (fin_a > fin_b) ? fin_a : fin_b;
        lat = lat_shadow[op[4:3]][op[2:0]*LAT_BITS +: LAT_BITS];
        sum = r.start + lat;
        r.finish = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
        if (r.finish > deepest_fin)
            deepest_fin = r.finish;
        r.depth = deepest_fin;
        writer_known[d] = 1'b1;
        writer_idx[d] = r.index;
        writer_fin[d] = r.finish;
        return r;
    endfunction

    task automatic send_inst(input logic [OP_BITS-1:0] op, input logic [REG_BITS-1:0] d,
                             input logic [REG_BITS-1:0] a, input logic [REG_BITS-1:0] b,
                             input logic np);
        int gap;
        depth_result_t exp_res;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        dest_reg <= d;
        source_a <= a;
        source_b <= b;
        new_program <= np;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_res = track_instruction(op, d, a, b, np);
        pending_results = {pending_results, exp_res};
        n_sent++;
        if (np)
            n_programs++;
    endtask

    // let the block run empty before touching its registers
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_lat_word(input lat_reg_t sel, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        lat_shadow[sel] = value;
    endtask

    task automatic load_latencies(input logic [CFG_BITS-1:0] w0, input logic [CFG_BITS-1:0] w1,
                                  input logic [CFG_BITS-1:0] w2, input logic [CFG_BITS-1:0] w3);
        write_lat_word(LAT_WORD_0, w0);
        write_lat_word(LAT_WORD_1, w1);
        write_lat_word(LAT_WORD_2, w2);
        write_lat_word(LAT_WORD_3, w3);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        depth_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, index %0d",
                             $time, inst_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("inst_index", longint'(want.index), longint'(inst_index));
                check_field("producer_a", longint'(want.prod_a), longint'(producer_a));
                check_field("producer_b", longint'(want.prod_b), longint'(producer_b));
                check_field("start_depth", longint'(want.start), longint'(start_depth));
                check_field("finish_time", longint'(want.finish), longint'(finish_time));
                check_field("program_depth", longint'(want.depth), longint'(program_depth));
                check_field("index_overflow", longint'(want.overflow),
                            longint'(index_overflow));
                n_checked++;
                if (want.overflow)
                    n_overflow++;
                if (want.finish == TIME_MAX)
                    n_saturated++;
            end
        end
    end

    // receiver stalls: mostly short, now and then long
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70)
                out_ready <= 1'b1;
            else if (ready_roll < 95)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    task automatic test_directed();
        load_latencies(64'h4020_1008_0402_0100, 64'h1111_2222_3333_4444,
                       64'hF0E1_D2C3_B4A5_9687, 64'hFF01_0203_0405_0607);
        send_inst(5'd0, 5'd0, 5'd0, 5'd0, 1'b1);     // nothing written yet
        send_inst(5'd31, 5'd31, 5'd31, 5'd31, 1'b0);
        send_inst(5'd1, 5'd1, 5'd0, 5'd31, 1'b0);    // two producers, later one wins
        send_inst(5'd31, 5'd1, 5'd1, 5'd1, 1'b0);    // reads its own destination
        send_inst(5'd2, 5'd2, 5'd1, 5'd0, 1'b0);
        send_inst(5'd24, 5'd0, 5'd2, 5'd2, 1'b0);
        send_inst(5'd7, 5'd31, 5'd0, 5'd1, 1'b1);    // restart mid-stream
        send_inst(5'd31, 5'd0, 5'd31, 5'd0, 1'b0);
        wait_drain();
        send_inst(5'd0, 5'd5, 5'd0, 5'd31, 1'b0);
        send_inst(5'd16, 5'd31, 5'd5, 5'd0, 1'b0);
        send_inst(5'd8, 5'd3, 5'd3, 5'd3, 1'b0);
        send_inst(5'd15, 5'd3, 5'd31, 5'd3, 1'b0);
        send_inst(5'd23, 5'd10, 5'd21, 5'd10, 1'b1);
        send_inst(5'd31, 5'd21, 5'd10, 5'd10, 1'b0);
    endtask

    task automatic test_random_traces();
        int sent;
        int len;
        logic [CFG_BITS-1:0] w [NUM_LAT_WORDS];
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drain();
            for (int i = 0; i < NUM_LAT_WORDS; i++)
            begin
                if (phase == 0)
                    w[i] = '0;
                else if (phase == 1)
                    w[i] = '1;
                else
                    w[i] = {$urandom, $urandom};
            end
            load_latencies(w[0], w[1], w[2], w[3]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 30);
                quiet = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < len && sent < PHASE_ITEMS; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_inst(OP_BITS'($urandom_range(0, 31)),
                                  REG_BITS'($urandom_range(0, 31)),
                                  REG_BITS'($urandom_range(0, 31)),
                                  REG_BITS'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)));
                    else
                        send_inst(OP_BITS'($urandom_range(0, 31)), pick_reg(), pick_reg(),
                                  pick_reg(), k == 0);
                    sent++;
                    // sender holds off until every result is back
                    if (phase == 2 && sent == PHASE_ITEMS / 2)
                        wait_drain();
                end
                quiet = 1'b0;
            end
        end
    endtask

    // one dependent chain through a single register with every latency at its maximum
    task automatic test_long_chain();
        wait_drain();
        load_latencies('1, '1, '1, '1);
        quiet = 1'b1;
        send_inst(OP_BITS'($urandom_range(0, 31)), 5'd5, 5'd5,
                  REG_BITS'($urandom_range(0, 31)), 1'b1);
        for (int k = 1; k < CHAIN_LEN; k++)
            send_inst(OP_BITS'($urandom_range(0, 31)), 5'd5, 5'd5,
                      REG_BITS'($urandom_range(0, 31)), 1'b0);
        send_inst(5'd0, 5'd1, 5'd5, 5'd1, 1'b1);
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = LAT_WORD_0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = '0;
        dest_reg = '0;
        source_a = '0;
        source_b = '0;
        new_program = 1'b0;
        out_ready = 1'b0;
        for (int i = 0; i < NUM_LAT_WORDS; i++)
            lat_shadow[i] = '0;
        clear_program_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traces();
        test_long_chain();

        wait_drain();
        repeat (8) @(posedge clk);
        $display("sent %0d instructions in %0d programs, checked %0d results",
                 n_sent, n_programs, n_checked);
        $display("%0d results past a full index counter, %0d with saturated finish time",
                 n_overflow, n_saturated);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
src/dtrk_pkg.sv
src/dtrk_front.sv
src/dtrk_queue.sv
src/dtrk_back.sv
src/dataflow_dependency_depth_tracker.sv
tb/testbench.sv
